[hw/rtl/pafd_pkg.sv]
package pafd_pkg;

	// Node table and interval window geometry
	localparam int NODES   = 16;
	localparam int NODE_W  = 4;
	localparam int WINDOW  = 32;
	localparam int HEAD_W  = 5;
	localparam int CNT_W   = 6;
	localparam int RING_AW = NODE_W + HEAD_W;

	// Field widths
	localparam int TIME_W = 48;
	localparam int SUM_W  = 53;
	localparam int PHI_W  = 15;
	localparam int THR_W  = 14;
	localparam int WS_W   = 6;
	localparam int HLTH_W = 2;
	localparam int CMD_W  = 2;

	// Phi arithmetic: num = el * (cnt * log10(e) in Q16), den = sum << 8
	localparam int KW     = 21;
	localparam int LO_W   = 24;
	localparam int HI_W   = TIME_W - LO_W;
	localparam int PP_W   = LO_W + KW;
	localparam int NUM_W  = PP_W + LO_W;
	localparam int QBITS  = 12;
	localparam int STEP_W = 4;
	localparam int DSH_W  = SUM_W + 8 + QBITS - 1;
	localparam int DEN_W  = SUM_W + 8;

	localparam logic [14:0]      LOG10E_Q16 = 15'd28462;
	localparam logic [QBITS-1:0] PHI_CAP_Q8 = 12'd2560;
	localparam logic [PHI_W-1:0] PHI_SAT_Q8 = 15'd25600;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE    = 2'd2;

	// Health codes
	localparam logic [HLTH_W-1:0] HEALTH_OK        = 2'd0;
	localparam logic [HLTH_W-1:0] HEALTH_SUSPECTED = 2'd1;
	localparam logic [HLTH_W-1:0] HEALTH_BAD       = 2'd2;

	// Configuration register indexes
	localparam logic REG_WINDOW_SIZE   = 1'b0;
	localparam logic REG_PHI_THRESHOLD = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic evict_rd;
		logic evict_sub;
		logic push;
		logic wclear;
		logic clear;
		logic hb_set;
		logic wb;
		logic mul0;
		logic mul1;
		logic mul2;
		logic div_init;
		logic div_step;
		logic finish;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_hb;
		logic is_remove;
		logic do_push;
		logic eff_zero;
		logic need_evict;
		logic phi_zero;
		logic div_last;
		logic out_free;
	} dp_stat_t;

endpackage

[hw/rtl/phi_accrual_failure_detector.sv]
// Phi accrual failure detector for 16 numbered nodes.
// Slave stream: one transaction is one command. s_tuser carries the command
// (heartbeat, query, remove), s_tdata carries node and time in milliseconds.
// A heartbeat records its time and pushes the interval since the previous
// heartbeat into a per-node window of min(window_size, 32) intervals with a running
// sum; remove forgets the node. Every command yields one master transaction
// with the node's status: known flag, phi in Q8, health class, last heartbeat.
// The phi division runs only when phi is not zero, and each interval dropped
// from a full window costs one read of the interval ring memory. s_tready
// rises with m_tvalid. The 12-step restoring divider and the per-item
// sequencer set the rate: one command at a time.
// The configuration port (cfg_we, cfg_addr, cfg_wdata) writes window_size
// (index 0) or phi_threshold_q8 (index 1); the user must write it only while
// idle, as the block itself does not enforce this.
// Reset clears all node state and loads window 32 and threshold 2048; the
// interval ring needs no clearing. A result waits in the output register
// while m_tready is low; the next command is taken meanwhile but is not
// finished until that result has left.
module phi_accrual_failure_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,    // node[3:0], time_ms[51:4], zero fill
	input  logic [1:0]  s_tuser,    // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,    // known[0], phi_q8[15:1], health[17:16],
	                                // last_heartbeat_ms[65:18], zero fill
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [13:0] cfg_wdata
);

	logic [pafd_pkg::WS_W-1:0]   window_size_q;
	logic [pafd_pkg::THR_W-1:0]  phi_threshold_q;
	pafd_pkg::dp_cmd_t           cmd;
	pafd_pkg::dp_stat_t          stat;
	logic                        known;
	logic [pafd_pkg::PHI_W-1:0]  phi_q8;
	logic [pafd_pkg::HLTH_W-1:0] health;
	logic [pafd_pkg::TIME_W-1:0] last_heartbeat_ms;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q   <= pafd_pkg::WS_W'(32);
			phi_threshold_q <= pafd_pkg::THR_W'(2048);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				pafd_pkg::REG_WINDOW_SIZE: begin
					window_size_q <= cfg_wdata[pafd_pkg::WS_W-1:0];
				end
				pafd_pkg::REG_PHI_THRESHOLD: begin
					phi_threshold_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	pafd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pafd_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.window_size       (window_size_q),
		.phi_threshold_q8  (phi_threshold_q),
		.command           (s_tuser),
		.node              (s_tdata[3:0]),
		.time_ms           (s_tdata[51:4]),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.known             (known),
		.phi_q8            (phi_q8),
		.health            (health),
		.last_heartbeat_ms (last_heartbeat_ms)
	);

	// Result packing
	assign m_tdata = {6'd0, last_heartbeat_ms, health, phi_q8, known};

endmodule

[hw/rtl/pafd_ram.sv]
module pafd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/pafd_ctrl.sv]
module pafd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  pafd_pkg::dp_stat_t  stat,
	output pafd_pkg::dp_cmd_t   cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_EV_RD,
		ST_EV_SUB,
		ST_PUSH,
		ST_HB_SET,
		ST_WB,
		ST_PHI0,
		ST_MUL1,
		ST_MUL2,
		ST_DIV_INIT,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;
	state_t state_nx;

	assign s_tready = (state_q == ST_IDLE);

	// Next state and datapath commands
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_nx = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				priority if (stat.do_push) begin
					priority if (stat.eff_zero) begin
						cmd.wclear = 1'b1;
						state_nx   = ST_HB_SET;
					end else if (stat.need_evict) begin
						state_nx = ST_EV_RD;
					end else begin
						state_nx = ST_PUSH;
					end
				end else if (stat.is_hb) begin
					state_nx = ST_HB_SET;
				end else if (stat.is_remove) begin
					cmd.clear = 1'b1;
					state_nx  = ST_WB;
				end else begin
					state_nx = ST_WB;
				end
			end
			ST_EV_RD: begin
				cmd.evict_rd = 1'b1;
				state_nx     = ST_EV_SUB;
			end
			ST_EV_SUB: begin
				cmd.evict_sub = 1'b1;
				state_nx      = ST_DECIDE;
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_nx = ST_HB_SET;
			end
			ST_HB_SET: begin
				cmd.hb_set = 1'b1;
				state_nx   = ST_WB;
			end
			ST_WB: begin
				cmd.wb   = 1'b1;
				state_nx = ST_PHI0;
			end
			ST_PHI0: begin
				if (stat.phi_zero) begin
					state_nx = ST_FIN;
				end else begin
					cmd.mul0 = 1'b1;
					state_nx = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_nx = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_nx = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_nx     = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

[hw/rtl/pafd_dp.sv]
module pafd_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pafd_pkg::dp_cmd_t                   cmd,
	output pafd_pkg::dp_stat_t                  stat,
	input  logic [pafd_pkg::WS_W-1:0]           window_size,
	input  logic [pafd_pkg::THR_W-1:0]          phi_threshold_q8,
	input  logic [pafd_pkg::CMD_W-1:0]          command,
	input  logic [pafd_pkg::NODE_W-1:0]         node,
	input  logic [pafd_pkg::TIME_W-1:0]         time_ms,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic                                known,
	output logic [pafd_pkg::PHI_W-1:0]          phi_q8,
	output logic [pafd_pkg::HLTH_W-1:0]         health,
	output logic [pafd_pkg::TIME_W-1:0]         last_heartbeat_ms
);

	// Per-node state
	logic [pafd_pkg::NODES-1:0]  valid_q;
	logic [pafd_pkg::TIME_W-1:0] last_q [pafd_pkg::NODES];
	logic [pafd_pkg::CNT_W-1:0]  cnt_q  [pafd_pkg::NODES];
	logic [pafd_pkg::HEAD_W-1:0] head_q [pafd_pkg::NODES];
	logic [pafd_pkg::SUM_W-1:0]  sum_q  [pafd_pkg::NODES];

	// Working copy of the addressed node
	logic [pafd_pkg::CMD_W-1:0]  cmd_q;
	logic [pafd_pkg::NODE_W-1:0] node_q;
	logic [pafd_pkg::TIME_W-1:0] time_q;
	logic [pafd_pkg::TIME_W-1:0] iv_q;
	logic                        cur_valid_q;
	logic [pafd_pkg::TIME_W-1:0] cur_last_q;
	logic [pafd_pkg::CNT_W-1:0]  cur_cnt_q;
	logic [pafd_pkg::HEAD_W-1:0] cur_head_q;
	logic [pafd_pkg::SUM_W-1:0]  cur_sum_q;

	// Phi arithmetic
	logic [pafd_pkg::TIME_W-1:0] el_q;
	logic [pafd_pkg::KW-1:0]     k_q;
	logic [pafd_pkg::PP_W-1:0]   plo_q;
	logic [pafd_pkg::PP_W-1:0]   phi_hi_q;
	logic [pafd_pkg::NUM_W-1:0]  num_q;
	logic [pafd_pkg::DSH_W-1:0]  dsh_q;
	logic [pafd_pkg::QBITS-1:0]  q_q;
	logic [pafd_pkg::STEP_W-1:0] step_q;

	logic [pafd_pkg::CNT_W-1:0]   eff;
	logic [pafd_pkg::HEAD_W-1:0]  slot;
	logic [pafd_pkg::TIME_W-1:0]  ram_rdata;
	logic                         div_ge;
	logic [pafd_pkg::DEN_W-1:0]   den;
	logic                         sat;
	logic [pafd_pkg::PHI_W-1:0]   phi_fin;
	logic [pafd_pkg::HLTH_W-1:0]  health_fin;

	// Effective window and push slot
	assign eff  = (window_size > pafd_pkg::CNT_W'(pafd_pkg::WINDOW)) ?
		pafd_pkg::CNT_W'(pafd_pkg::WINDOW) : window_size;
	assign slot = cur_head_q + cur_cnt_q[pafd_pkg::HEAD_W-1:0];

	// Interval ring, one row of WINDOW entries per node
	pafd_ram #(
		.WIDTH (pafd_pkg::TIME_W),
		.DEPTH (pafd_pkg::NODES * pafd_pkg::WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (cmd.push),
		.waddr ({node_q, slot}),
		.wdata (iv_q),
		.re    (cmd.evict_rd),
		.raddr ({node_q, cur_head_q}),
		.rdata (ram_rdata)
	);

	// Status toward the controller
	assign stat.is_hb      = (cmd_q == pafd_pkg::CMD_HEARTBEAT);
	assign stat.is_remove  = (cmd_q == pafd_pkg::CMD_REMOVE);
	assign stat.do_push    = stat.is_hb && cur_valid_q && (cur_last_q != '0);
	assign stat.eff_zero   = (eff == '0);
	assign stat.need_evict = (cur_cnt_q >= eff);
	assign stat.phi_zero   = !cur_valid_q || (cur_cnt_q < pafd_pkg::CNT_W'(2)) ||
		(cur_sum_q == '0);
	assign stat.div_last   = (step_q == '0);
	assign stat.out_free   = !m_tvalid || m_tready;

	// Restoring divider compare, then saturation and health class
	assign div_ge = ({{(pafd_pkg::DSH_W - pafd_pkg::NUM_W){1'b0}}, num_q} >= dsh_q);
	assign den    = {cur_sum_q, 8'd0};
	assign sat    = (num_q >= {{(pafd_pkg::NUM_W - pafd_pkg::DEN_W){1'b0}}, den}) ||
		(q_q > pafd_pkg::PHI_CAP_Q8);

	always_comb begin
		priority if (stat.phi_zero) begin
			phi_fin = '0;
		end else if (sat) begin
			phi_fin = pafd_pkg::PHI_SAT_Q8;
		end else begin
			phi_fin = {{(pafd_pkg::PHI_W - pafd_pkg::QBITS){1'b0}}, q_q};
		end
		priority if (phi_fin >= {phi_threshold_q8, 1'b0}) begin
			health_fin = pafd_pkg::HEALTH_BAD;
		end else if (phi_fin >= {1'b0, phi_threshold_q8}) begin
			health_fin = pafd_pkg::HEALTH_SUSPECTED;
		end else begin
			health_fin = pafd_pkg::HEALTH_OK;
		end
	end

	// Per-node table: written back once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < pafd_pkg::NODES; i++) begin
				last_q[i] <= '0;
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
				sum_q[i]  <= '0;
			end
		end else if (cmd.wb) begin
			valid_q[node_q] <= cur_valid_q;
			last_q[node_q]  <= cur_last_q;
			cnt_q[node_q]   <= cur_cnt_q;
			head_q[node_q]  <= cur_head_q;
			sum_q[node_q]   <= cur_sum_q;
		end
	end

	// Working registers of the current item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q       <= command;
			node_q      <= node;
			time_q      <= time_ms;
			iv_q        <= time_ms - last_q[node];
			cur_valid_q <= valid_q[node];
			cur_last_q  <= last_q[node];
			cur_cnt_q   <= cnt_q[node];
			cur_head_q  <= head_q[node];
			cur_sum_q   <= sum_q[node];
		end else if (cmd.evict_sub) begin
			cur_sum_q  <= cur_sum_q - {{(pafd_pkg::SUM_W - pafd_pkg::TIME_W){1'b0}}, ram_rdata};
			cur_head_q <= cur_head_q + pafd_pkg::HEAD_W'(1);
			cur_cnt_q  <= cur_cnt_q - pafd_pkg::CNT_W'(1);
		end else if (cmd.push) begin
			cur_sum_q <= cur_sum_q + {{(pafd_pkg::SUM_W - pafd_pkg::TIME_W){1'b0}}, iv_q};
			cur_cnt_q <= cur_cnt_q + pafd_pkg::CNT_W'(1);
		end else if (cmd.wclear) begin
			cur_sum_q <= '0;
			cur_cnt_q <= '0;
		end else if (cmd.clear) begin
			cur_valid_q <= 1'b0;
			cur_last_q  <= '0;
			cur_cnt_q   <= '0;
			cur_head_q  <= '0;
			cur_sum_q   <= '0;
		end else if (cmd.hb_set) begin
			cur_valid_q <= 1'b1;
			cur_last_q  <= time_q;
		end
	end

	// Multiply in split halves, then a 12-step restoring division
	always_ff @(posedge clk) begin
		if (cmd.mul0) begin
			el_q <= time_q - cur_last_q;
			k_q  <= {{(pafd_pkg::KW - pafd_pkg::CNT_W){1'b0}}, cur_cnt_q} *
				{{(pafd_pkg::KW - 15){1'b0}}, pafd_pkg::LOG10E_Q16};
		end
		if (cmd.mul1) begin
			plo_q <= {{pafd_pkg::KW{1'b0}}, el_q[pafd_pkg::LO_W-1:0]} *
				{{pafd_pkg::LO_W{1'b0}}, k_q};
		end
		if (cmd.mul2) begin
			phi_hi_q <= {{(pafd_pkg::PP_W - pafd_pkg::HI_W){1'b0}},
				el_q[pafd_pkg::TIME_W-1:pafd_pkg::LO_W]} * {{pafd_pkg::LO_W{1'b0}}, k_q};
		end
		if (cmd.div_init) begin
			num_q  <= {{pafd_pkg::LO_W{1'b0}}, plo_q} + {phi_hi_q, {pafd_pkg::LO_W{1'b0}}};
			dsh_q  <= {cur_sum_q, {(pafd_pkg::DSH_W - pafd_pkg::SUM_W){1'b0}}};
			q_q    <= '0;
			step_q <= pafd_pkg::STEP_W'(pafd_pkg::QBITS - 1);
		end else if (cmd.div_step) begin
			if (div_ge) begin
				num_q <= num_q - dsh_q[pafd_pkg::NUM_W-1:0];
			end
			q_q    <= {q_q[pafd_pkg::QBITS-2:0], div_ge};
			dsh_q  <= dsh_q >> 1;
			step_q <= step_q - pafd_pkg::STEP_W'(1);
		end
	end

	// Output register: holds a result while the next item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.finish) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			known             <= cur_valid_q;
			phi_q8            <= cur_valid_q ? phi_fin : '0;
			health            <= cur_valid_q ? health_fin : pafd_pkg::HEALTH_OK;
			last_heartbeat_ms <= cur_valid_q ? cur_last_q : '0;
		end
	end

endmodule

[verif/phi_accrual_failure_detector_checker.sv]
`timescale 1ns / 100ps

module phi_accrual_failure_detector_checker
	import pafd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,    // node[3:0], time_ms[51:4], zero fill
	input  logic [1:0]  s_tuser,    // command[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,    // known[0], phi_q8[15:1], health[17:16],
	                                // last_heartbeat_ms[65:18], zero fill
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [13:0] cfg_wdata,
	output int          fail_count,
	output int          pending,
	output int          results_seen,
	output int          saturated_seen,
	output int          suspected_seen
);

	typedef struct packed {
		logic              known;
		logic [PHI_W-1:0]  phi_q8;
		logic [HLTH_W-1:0] health;
		logic [TIME_W-1:0] last_hb;
	} status_t;

	// Shadow copy of the registers and the node table
	logic [WS_W-1:0]   win_size;
	logic [THR_W-1:0]  phi_thr;
	logic              known_tbl [NODES];
	logic [TIME_W-1:0] beat_time [NODES];
	logic [TIME_W-1:0] iv_ring   [NODES][WINDOW];
	logic [CNT_W-1:0]  iv_count  [NODES];
	logic [HEAD_W-1:0] iv_head   [NODES];
	logic [63:0]       iv_sum    [NODES];

	// Expected results in order, kept in a small ring
	status_t    exp_ring [16];
	logic [3:0] exp_wr;
	logic [3:0] exp_rd;
	int         exp_cnt;
	status_t    want;
	status_t    got;
	int         errs;
	int         seen;
	int         sat;
	int         susp;

	task automatic clear_node(input logic [NODE_W-1:0] n);
		known_tbl[n] = 1'b0;
		beat_time[n] = '0;
		iv_count[n]  = '0;
		iv_head[n]   = '0;
		iv_sum[n]    = '0;
	endtask

	// Sliding window: drop oldest intervals until there is room, then append
	task automatic push_interval(input logic [NODE_W-1:0] n, input logic [TIME_W-1:0] iv);
		logic [CNT_W-1:0]  eff;
		logic [HEAD_W-1:0] slot;
		eff = (win_size > CNT_W'(WINDOW)) ? CNT_W'(WINDOW) : win_size;
		if (eff == '0) begin
			iv_count[n] = '0;
			iv_sum[n]   = '0;
		end else begin
			while (iv_count[n] >= eff) begin
				iv_sum[n]   = iv_sum[n] - 64'(iv_ring[n][iv_head[n]]);
				iv_head[n]  = iv_head[n] + HEAD_W'(1);
				iv_count[n] = iv_count[n] - CNT_W'(1);
			end
			slot = iv_head[n] + iv_count[n][HEAD_W-1:0];
			iv_ring[n][slot] = iv;
			iv_count[n] = iv_count[n] + CNT_W'(1);
			iv_sum[n]   = iv_sum[n] + 64'(iv);
		end
	endtask

	// phi in Q8 = floor(elapsed * count * log10(e)_Q16 / (sum * 256)), capped
	function automatic logic [PHI_W-1:0] phi_estimate(input logic [NODE_W-1:0] n,
			input logic [TIME_W-1:0] now_ms);
		logic [TIME_W-1:0] elapsed;
		logic [127:0]      num;
		logic [127:0]      den;
		logic [127:0]      quo;
		if (iv_count[n] < CNT_W'(2) || iv_sum[n] == '0)
			return '0;
		elapsed = now_ms - beat_time[n];
		num = 128'(elapsed) * 128'(iv_count[n]) * 128'(LOG10E_Q16);
		den = 128'(iv_sum[n]) << 8;
		quo = num / den;
		return (quo > 128'(PHI_CAP_Q8)) ? PHI_SAT_Q8 : PHI_W'(quo);
	endfunction

	// Update the node table for one command and build the expected status
	task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] n,
			input logic [TIME_W-1:0] at_ms, output status_t st);
		logic [PHI_W-1:0] phi;
		st = '0;
		case (cmd)
			CMD_HEARTBEAT: begin
				if (known_tbl[n] && beat_time[n] != '0)
					push_interval(n, at_ms - beat_time[n]);
				known_tbl[n] = 1'b1;
				beat_time[n] = at_ms;
			end
			CMD_REMOVE: begin
				clear_node(n);
			end
			default: begin
			end
		endcase
		if (known_tbl[n]) begin
			phi = phi_estimate(n, at_ms);
			st.known   = 1'b1;
			st.phi_q8  = phi;
			st.last_hb = beat_time[n];
			if (phi >= {phi_thr, 1'b0})
				st.health = HEALTH_BAD;
			else if (phi >= {1'b0, phi_thr})
				st.health = HEALTH_SUSPECTED;
			else
				st.health = HEALTH_OK;
		end
	endtask

	// Register writes, result compare, then prediction of accepted commands
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size = WS_W'(32);
			phi_thr  = THR_W'(2048);
			for (int i = 0; i < NODES; i++)
				clear_node(NODE_W'(i));
			exp_wr  = '0;
			exp_rd  = '0;
			exp_cnt = 0;
			errs = 0;
			seen = 0;
			sat  = 0;
			susp = 0;
			fail_count     <= 0;
			pending        <= 0;
			results_seen   <= 0;
			saturated_seen <= 0;
			suspected_seen <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_WINDOW_SIZE)
					win_size = cfg_wdata[WS_W-1:0];
				else
					phi_thr = cfg_wdata[THR_W-1:0];
			end

			if (m_tvalid && m_tready) begin
				got.known   = m_tdata[0];
				got.phi_q8  = m_tdata[15:1];
				got.health  = m_tdata[17:16];
				got.last_hb = m_tdata[65:18];
				seen++;
				if (got.phi_q8 == PHI_SAT_Q8)
					sat++;
				if (got.health == HEALTH_SUSPECTED)
					susp++;
				if (exp_cnt == 0) begin
					$error("unexpected result transaction: %h", m_tdata);
					errs++;
				end else begin
					want    = exp_ring[exp_rd];
					exp_rd  = exp_rd + 4'd1;
					exp_cnt = exp_cnt - 1;
					if (got.known !== want.known) begin
						$error("known: expected %0d, actual %0d", want.known, got.known);
						errs++;
					end
					if (got.phi_q8 !== want.phi_q8) begin
						$error("phi_q8: expected %0d, actual %0d", want.phi_q8, got.phi_q8);
						errs++;
					end
					if (got.health !== want.health) begin
						$error("health: expected %0d, actual %0d", want.health, got.health);
						errs++;
					end
					if (got.last_hb !== want.last_hb) begin
						$error("last_heartbeat_ms: expected %0d, actual %0d",
							want.last_hb, got.last_hb);
						errs++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				apply_command(s_tuser, s_tdata[3:0], s_tdata[51:4], want);
				exp_ring[exp_wr] = want;
				exp_wr  = exp_wr + 4'd1;
				exp_cnt = exp_cnt + 1;
			end

			fail_count     <= errs;
			pending        <= exp_cnt;
			results_seen   <= seen;
			saturated_seen <= sat;
			suspected_seen <= susp;
		end
	end

endmodule

[verif/phi_accrual_failure_detector_tb.sv]
`timescale 1ns / 100ps

module phi_accrual_failure_detector_tb;
	import pafd_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 103;

	// Code 3 has no command of its own; the block reports status as for a query
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Window and threshold per phase; some window words carry junk above bit 5
	localparam logic [13:0] WS_PLAN [PHASES] = '{
		14'd32, 14'h2A01, 14'd2, 14'd8, 14'd0, 14'h3FFF, 14'd4, 14'd32, 14'd17, 14'd3
	};
	localparam logic [13:0] THR_PLAN [PHASES] = '{
		14'd2048, 14'd0, 14'd12800, 14'd1024, 14'd300, 14'd16383, 14'd2560, 14'd512,
		14'd1500, 14'd1800
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata   = '0;    // node[3:0], time_ms[51:4], zero fill
	logic [1:0]  s_tuser   = '0;    // command[1:0]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [71:0] m_tdata;           // known[0], phi_q8[15:1], health[17:16],
	                                // last_heartbeat_ms[65:18], zero fill
	logic        cfg_we    = 1'b0;
	logic        cfg_addr  = 1'b0;
	logic [13:0] cfg_wdata = '0;

	int fail_count;
	int pending;
	int results_seen;
	int saturated_seen;
	int suspected_seen;

	logic              calm = 1'b0;
	int                stall_left = 0;
	int                quiet = 0;
	int                sent = 0;
	logic [TIME_W-1:0] now_ms  [NODES];
	int unsigned       beat_ms [NODES];

	phi_accrual_failure_detector dut (.*);

	phi_accrual_failure_detector_checker u_checker (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Result side: ready with random stall bursts, always ready when calm
	always @(posedge clk) begin
		if (calm) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= int'($urandom_range(0, 8));
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles with no transaction on either stream
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet == IDLE_LIMIT) begin
			$error("no transaction for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, pending);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// One command transaction, optionally preceded by an idle burst
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] n,
			input logic [TIME_W-1:0] at_ms);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = int'($urandom_range(1, 9));
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0, at_ms, n};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Stop sending and wait for every outstanding status; the first edge lets
	// the count take in the command accepted last
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [13:0] ws_word, input logic [13:0] thr_word);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_WINDOW_SIZE;
		cfg_wdata <= ws_word;
		@(posedge clk);
		cfg_addr  <= REG_PHI_THRESHOLD;
		cfg_wdata <= thr_word;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly regular heartbeat trains with queries around the suspicion range,
	// plus removes, the unused code and fully random noise
	task automatic random_command();
		logic [NODE_W-1:0] n;
		logic [CMD_W-1:0]  cmd;
		logic [TIME_W-1:0] at_ms;
		int unsigned       step;
		int                pick;
		n = ($urandom_range(0, 9) < 7) ? NODE_W'($urandom_range(0, 3)) : NODE_W'($urandom);
		pick = int'($urandom_range(0, 99));
		if (pick < 48) begin
			cmd = CMD_HEARTBEAT;
			if ($urandom_range(0, 49) == 0)
				beat_ms[n] = $urandom_range(20, 3000);
			step = beat_ms[n] - beat_ms[n] / 4 + $urandom_range(0, beat_ms[n] / 2);
			now_ms[n] = now_ms[n] + TIME_W'(step);
			at_ms = now_ms[n];
		end else if (pick < 84) begin
			cmd = CMD_QUERY;
			at_ms = now_ms[n] + TIME_W'($urandom_range(0, 30 * beat_ms[n]));
		end else if (pick < 89) begin
			cmd = CMD_REMOVE;
			at_ms = now_ms[n] + TIME_W'($urandom_range(0, 1000));
		end else if (pick < 94) begin
			cmd = CMD_UNUSED;
			at_ms = now_ms[n] + TIME_W'($urandom_range(0, 10 * beat_ms[n]));
		end else begin
			cmd = CMD_W'($urandom);
			at_ms = TIME_W'({$urandom, $urandom});
			if (cmd == CMD_HEARTBEAT)
				now_ms[n] = at_ms;
		end
		send_command(cmd, n, at_ms);
	endtask

	initial begin
		for (int i = 0; i < NODES; i++) begin
			now_ms[i]  = TIME_W'($urandom_range(1, 1000000));
			beat_ms[i] = $urandom_range(50, 2000);
		end
		// Node 2 runs across the top of the time range
		now_ms[2] = 48'hFFFF_FFFF_FFFF - 48'd20000;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Unknown nodes report an all-zero status whatever the command
		send_command(CMD_QUERY,  4'd0, 48'd5);
		send_command(CMD_REMOVE, 4'd1, 48'd5);
		send_command(CMD_UNUSED, 4'd2, 48'd5);
		// Heartbeat at time zero stores zero, so the next one adds no interval
		send_command(CMD_HEARTBEAT, 4'd0, 48'd0);
		send_command(CMD_HEARTBEAT, 4'd0, 48'd1000);
		send_command(CMD_HEARTBEAT, 4'd0, 48'd2000);
		send_command(CMD_QUERY,     4'd0, 48'd2500);
		send_command(CMD_HEARTBEAT, 4'd0, 48'd3000);
		send_command(CMD_QUERY,     4'd0, 48'd3500);
		send_command(CMD_QUERY,     4'd0, 48'd9000);
		send_command(CMD_QUERY,     4'd0, 48'd100000);
		// Query time before the last heartbeat wraps and saturates
		send_command(CMD_QUERY,     4'd0, 48'd2999);
		send_command(CMD_UNUSED,    4'd0, 48'd4000);
		// Intervals that wrap over the top of the time range
		send_command(CMD_HEARTBEAT, 4'd15, 48'hFFFF_FFFF_FFFF);
		send_command(CMD_HEARTBEAT, 4'd15, 48'd5);
		send_command(CMD_HEARTBEAT, 4'd15, 48'd11);
		send_command(CMD_QUERY,     4'd15, 48'hFFFF_FFFF_FFFF);
		send_command(CMD_QUERY,     4'd15, 48'd13);
		// Repeated heartbeat time: two zero intervals, zero sum
		send_command(CMD_HEARTBEAT, 4'd3, 48'd50);
		send_command(CMD_HEARTBEAT, 4'd3, 48'd50);
		send_command(CMD_HEARTBEAT, 4'd3, 48'd50);
		send_command(CMD_QUERY,     4'd3, 48'd80);
		// Remove forgets the node
		send_command(CMD_REMOVE,    4'd0, 48'd4100);
		send_command(CMD_QUERY,     4'd0, 48'd4200);
		send_command(CMD_HEARTBEAT, 4'd9, 48'hAAAA_AAAA_AAAA);
		send_command(CMD_HEARTBEAT, 4'd9, 48'h5555_5555_5555);

		// Random phases, each under its own window and threshold
		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p == PHASES - 1)
				calm <= 1'b1;
			set_config(WS_PLAN[p], THR_PLAN[p]);
			repeat (PHASE_ITEMS) random_command();
		end

		drain();
		repeat (30) @(posedge clk);

		$display("Sent %0d commands under %0d window/threshold settings, %0d results checked.",
			sent, PHASES + 1, results_seen);
		$display("Saturated phi seen %0d times, suspected health %0d times.",
			saturated_seen, suspected_seen);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
